// ===== rtl/bia_pkg.sv =====
// Shared types, request codes and the word-level zero search for the
// bitmap id allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bia_pkg;

    localparam int WORD_W     = 32;
    localparam int WORD_SEL_W = 5;
    localparam int ID_W       = 10;
    localparam int CFG_W      = 11;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_QUERY   = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    localparam logic [CFG_W-1:0] IDS_RESET = 11'd1024;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] id_in;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic            granted;
        logic            is_free;
    } out_t;

    typedef struct packed {
        logic                  found;
        logic [WORD_SEL_W-1:0] idx;
    } zero_pos_t;

    function automatic zero_pos_t lowest_zero(input logic [WORD_W-1:0] word);
        zero_pos_t res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!word[i]) begin
                res.found = 1'b1;
                res.idx   = WORD_SEL_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bia_word_store.sv =====
// Bitmap word memory: one synchronous read port, one write port, and a
// clearing sweep after reset. Uses bia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bia_word_store #(
    parameter int NUM_WORDS = 32,
    parameter int WA_W      = 5
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          rd_en,
    input  wire  [WA_W-1:0]              rd_addr,
    output logic [bia_pkg::WORD_W-1:0]   rd_data,
    input  wire                          wr_en,
    input  wire  [WA_W-1:0]              wr_addr,
    input  wire  [bia_pkg::WORD_W-1:0]   wr_data,
    output logic                         clr_busy
);

    logic [bia_pkg::WORD_W-1:0] mem [NUM_WORDS];
    logic [bia_pkg::WORD_W-1:0] rd_data_reg;
    logic [WA_W-1:0]            clr_addr_reg;
    logic [WA_W-1:0]            clr_addr_next;
    logic                       clr_busy_reg;
    logic                       clr_busy_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            if (32'(clr_addr_reg) == NUM_WORDS - 1)
                clr_busy_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire

// ===== rtl/bia_summary.sv =====
// Summary level: one full flag per bitmap word and the search for the lowest
// word that still holds a free id. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bia_summary #(
    parameter int NUM_WORDS = 32,
    parameter int WA_W      = 5
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              upd_en,
    input  wire  [WA_W-1:0]  upd_addr,
    input  wire              upd_full,
    output logic             any_free,
    output logic [WA_W-1:0]  first_addr
);

    logic [NUM_WORDS-1:0] full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= '0;
        else if (upd_en)
            full_reg[upd_addr] <= upd_full;
    end

    always_comb
    begin
        any_free   = 1'b0;
        first_addr = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                any_free   = 1'b1;
                first_addr = WA_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_id_allocator.sv =====
// Top level of the first-fit bitmap id allocator: request sequencer, pool
// register and result register. Uses bia_pkg, bia_word_store, bia_summary.
//
//   channel | signals                         | direction
//   in      | in_valid, in_ready, in_data     | request in
//   out     | out_valid, out_ready, out_data  | result out
//   cfg     | cfg_valid, cfg_ready, cfg_data  | pool size write
//
// Each request is accepted in ST_IDLE, whose accept edge issues the bitmap word
// read (word picked by the summary flags for allocate); ST_EXEC then modifies,
// writes back and loads the result register once that register is free.
// After reset a clearing sweep zeroes every bitmap word; in_ready stays low
// meanwhile, configuration writes are taken.
// A result held by out_ready low stalls the write-back stage, not the accept.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_id_allocator #(
    parameter int MAX_IDS = 1024
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  bia_pkg::in_t             in_data,
    output logic                           out_valid,
    input  wire                            out_ready,
    output bia_pkg::out_t                  out_data,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [bia_pkg::CFG_W-1:0]      cfg_data
);

    localparam int NUM_WORDS = (MAX_IDS + bia_pkg::WORD_W - 1) / bia_pkg::WORD_W;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int FID_W     = WA_W + bia_pkg::WORD_SEL_W;
    localparam int CNT_W     = $clog2(MAX_IDS + 1);
    localparam int EXT_W     = (CNT_W > bia_pkg::CFG_W) ? CNT_W : bia_pkg::CFG_W;
    localparam int CMP_W     = (EXT_W > FID_W) ? EXT_W : FID_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_IDS);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    bia_pkg::in_t                req_reg;
    bia_pkg::in_t                req_next;
    logic                        avail_reg;
    logic                        avail_next;
    logic [WA_W-1:0]             addr_reg;
    logic [WA_W-1:0]             addr_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    bia_pkg::out_t               out_data_reg;
    bia_pkg::out_t               out_data_next;
    logic [bia_pkg::CFG_W-1:0]   ids_reg;

    logic                        clr_busy;
    logic                        any_free;
    logic [WA_W-1:0]             first_addr;
    logic [bia_pkg::WORD_W-1:0]  rd_data;
    logic                        rd_en;
    logic [WA_W-1:0]             rd_addr;
    logic                        wr_en;
    logic [bia_pkg::WORD_W-1:0]  wr_data;

    logic [CMP_W-1:0]            cfg_ext;
    logic [CMP_W-1:0]            pool;
    logic [CMP_W-1:0]            in_id_ext;
    logic [CMP_W-1:0]            req_id_ext;
    logic [CMP_W-1:0]            cand;
    bia_pkg::zero_pos_t          lz;
    logic                        in_fire;
    logic                        exec_fire;
    logic                        id_in_pool;
    logic [bia_pkg::WORD_W-1:0]  sel_mask;

    bia_word_store #(
        .NUM_WORDS (NUM_WORDS),
        .WA_W      (WA_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (addr_reg),
        .wr_data  (wr_data),
        .clr_busy (clr_busy)
    );

    bia_summary #(
        .NUM_WORDS (NUM_WORDS),
        .WA_W      (WA_W)
    ) u_summary (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd_en     (wr_en),
        .upd_addr   (addr_reg),
        .upd_full   (&wr_data),
        .any_free   (any_free),
        .first_addr (first_addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ids_reg <= bia_pkg::IDS_RESET;
        else if (cfg_valid)
            ids_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;
    assign cfg_ext   = CMP_W'(ids_reg);
    assign pool      = (cfg_ext > MAX_CMP) ? MAX_CMP : cfg_ext;

    assign in_ready  = (state_reg == ST_IDLE) && !clr_busy;
    assign in_fire   = in_valid && in_ready;
    assign in_id_ext = CMP_W'(in_data.id_in);
    assign rd_en     = in_fire;
    assign rd_addr   = (in_data.req_type == bia_pkg::REQ_ALLOC) ? first_addr
                     : in_id_ext[FID_W-1:bia_pkg::WORD_SEL_W];

    assign req_id_ext = CMP_W'(req_reg.id_in);
    assign id_in_pool = req_id_ext < pool;
    assign lz         = bia_pkg::lowest_zero(rd_data);
    assign cand       = CMP_W'({addr_reg, lz.idx});
    assign exec_fire  = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        avail_next     = avail_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_data        = rd_data;
        sel_mask       = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    req_next   = in_data;
                    avail_next = any_free;
                    addr_next  = rd_addr;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                out_data_next = '0;
                case (req_reg.req_type)
                    bia_pkg::REQ_ALLOC:
                    begin
                        sel_mask = bia_pkg::WORD_W'(1) << lz.idx;
                        if (avail_reg && lz.found && (cand < pool))
                        begin
                            wr_en                    = exec_fire;
                            wr_data                  = rd_data | sel_mask;
                            out_data_next.granted    = 1'b1;
                            out_data_next.granted_id = bia_pkg::ID_W'(cand);
                        end
                    end
                    bia_pkg::REQ_QUERY:
                    begin
                        out_data_next.is_free = id_in_pool &&
                            !rd_data[req_reg.id_in[bia_pkg::WORD_SEL_W-1:0]];
                    end
                    bia_pkg::REQ_RELEASE:
                    begin
                        sel_mask = bia_pkg::WORD_W'(1) <<
                                   req_reg.id_in[bia_pkg::WORD_SEL_W-1:0];
                        if (id_in_pool)
                        begin
                            wr_en   = exec_fire;
                            wr_data = rd_data & ~sel_mask;
                        end
                    end
                    default:
                    begin
                        out_data_next = '0;
                    end
                endcase
                if (exec_fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    out_data_next = out_data_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= '0;
            avail_reg     <= 1'b0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            avail_reg     <= avail_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/bia_checker.sv =====
// Port-level checks for the bitmap id allocator, bound to the top level.
// Uses bia_pkg and bitmap_id_allocator.
`timescale 1ns / 1ps
`default_nettype none

module bia_checker (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    input  wire                        in_ready,
    input  wire                        out_valid,
    input  wire                        out_ready,
    input  wire  bia_pkg::out_t        out_data,
    input  wire                        cfg_valid,
    input  wire                        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request accepted while one is in flight");

    a_grant_or_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.granted && out_data.is_free))
        else $error("result carries both a grant and a query answer");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.granted |-> out_data.granted_id == '0)
        else $error("granted_id nonzero without a grant");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== tb/tb_bitmap_id_allocator.sv =====
// Self-checking testbench for bitmap_id_allocator: queue-fed request driver,
// result monitor with a first-fit predictor, and pool size writes between phases.
// Depends on bia_pkg and the bitmap_id_allocator RTL.
`timescale 1ns / 1ps

module tb_bitmap_id_allocator;

    localparam int          POOL_MAX   = 1024;
    localparam logic [1:0]  REQ_NONE   = 2'd3;
    localparam int          IDLE_LIMIT = 1000;
    localparam int          LONG_HOLD  = 120;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    bia_pkg::in_t                  in_data   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    bia_pkg::out_t                 out_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bia_pkg::CFG_W-1:0]     cfg_data  = '0;

    // predictor state
    logic [POOL_MAX-1:0]           id_used   = '0;
    logic [bia_pkg::CFG_W-1:0]     pool_cfg  = bia_pkg::IDS_RESET;

    bia_pkg::in_t         request_queue[$];
    bia_pkg::out_t        answer_queue[$];
    bia_pkg::out_t        want;

    int                   err_count     = 0;
    int                   idle_cycles   = 0;
    int                   send_gap      = 0;
    int                   recv_stall    = 0;
    int                   hold_left     = 0;
    logic                 calm          = 1'b0;
    logic                 long_hold_req = 1'b0;
    logic                 long_hold_done = 1'b0;

    bitmap_id_allocator #(
        .MAX_IDS   (POOL_MAX)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pool_limit();
        return (pool_cfg > bia_pkg::CFG_W'(POOL_MAX)) ? POOL_MAX : int'(pool_cfg);
    endfunction

    function automatic bia_pkg::out_t serve_request(input bia_pkg::in_t req);
        bia_pkg::out_t res;
        int            lim;
        res = '0;
        lim = pool_limit();
        case (req.req_type)
            bia_pkg::REQ_ALLOC:
            begin
                for (int i = 0; i < lim; i++)
                begin
                    if (!id_used[i])
                    begin
                        id_used[i]     = 1'b1;
                        res.granted_id = bia_pkg::ID_W'(i);
                        res.granted    = 1'b1;
                        break;
                    end
                end
            end
            bia_pkg::REQ_QUERY:
            begin
                if (int'(req.id_in) < lim && !id_used[req.id_in])
                    res.is_free = 1'b1;
            end
            bia_pkg::REQ_RELEASE:
            begin
                if (int'(req.id_in) < lim)
                    id_used[req.id_in] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int wanted);
        err_count++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, wanted);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                answer_queue.push_back(serve_request(in_data));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_queue.pop_front();
                    if (!calm && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 11);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            recv_stall     <= 0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answer_queue.size() == 0)
                begin
                    report_mismatch("unexpected result, granted_id", out_data.granted_id, 0);
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (out_data.granted_id !== want.granted_id)
                        report_mismatch("granted_id", out_data.granted_id, want.granted_id);
                    if (out_data.granted !== want.granted)
                        report_mismatch("granted", out_data.granted, want.granted);
                    if (out_data.is_free !== want.is_free)
                        report_mismatch("is_free", out_data.is_free, want.is_free);
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done <= 1'b1;
                hold_left      <= LONG_HOLD;
                out_ready      <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (recv_stall != 0)
            begin
                recv_stall <= recv_stall - 1;
                out_ready  <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                recv_stall <= $urandom_range(0, 10);
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_request(input logic [1:0] kind, input int id);
        bia_pkg::in_t req;
        req.req_type = kind;
        req.id_in    = bia_pkg::ID_W'(id);
        request_queue.push_back(req);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || answer_queue.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_pool_size(input int size);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= bia_pkg::CFG_W'(size);
        do
            @(posedge clk);
        while (!cfg_ready);
        pool_cfg = bia_pkg::CFG_W'(size);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int size, input int count);
        int eff;
        int span;
        int alloc_pct;
        int r;
        int id;
        logic [1:0] kind;
        wait_drained();
        write_pool_size(size);
        @(negedge clk);
        eff       = (size > POOL_MAX) ? POOL_MAX : size;
        span      = (eff == 0) ? 1 : ((eff < 64) ? eff : 64);
        alloc_pct = $urandom_range(25, 60);
        for (int k = 0; k < count; k++)
        begin
            r  = $urandom_range(0, 99);
            id = $urandom_range(0, POOL_MAX - 1);
            if (r < alloc_pct)
                kind = bia_pkg::REQ_ALLOC;
            else if (r < alloc_pct + (100 - alloc_pct) / 2)
                kind = bia_pkg::REQ_RELEASE;
            else if (r < 94)
                kind = bia_pkg::REQ_QUERY;
            else if (r < 97)
                kind = REQ_NONE;
            else
                kind = 2'($urandom_range(0, 3));
            if ((kind == bia_pkg::REQ_RELEASE || kind == bia_pkg::REQ_QUERY) && r < 97)
            begin
                case ($urandom_range(0, 9))
                    0: id = $urandom_range(0, POOL_MAX - 1);
                    1: id = (eff < POOL_MAX) ? eff : POOL_MAX - 1;
                    default: id = $urandom_range(0, span - 1);
                endcase
            end
            add_request(kind, id);
        end
    endtask

    initial
    begin
        int size;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default pool: lowest-first grants, query and release inside the pool
        add_request(bia_pkg::REQ_ALLOC, 0);
        add_request(bia_pkg::REQ_ALLOC, 1023);
        add_request(bia_pkg::REQ_ALLOC, 512);
        add_request(bia_pkg::REQ_QUERY, 0);
        add_request(bia_pkg::REQ_QUERY, 3);
        add_request(bia_pkg::REQ_QUERY, 1023);
        add_request(bia_pkg::REQ_RELEASE, 1);
        add_request(bia_pkg::REQ_QUERY, 1);
        add_request(bia_pkg::REQ_ALLOC, 1023);
        add_request(REQ_NONE, 1023);
        add_request(bia_pkg::REQ_RELEASE, 1023);
        add_request(bia_pkg::REQ_QUERY, 1023);

        // empty pool
        wait_drained();
        write_pool_size(0);
        @(negedge clk);
        add_request(bia_pkg::REQ_ALLOC, 0);
        add_request(bia_pkg::REQ_QUERY, 0);
        add_request(bia_pkg::REQ_RELEASE, 0);
        add_request(bia_pkg::REQ_QUERY, 1023);

        // shrunk pool: full, ids outside ignored
        wait_drained();
        write_pool_size(2);
        @(negedge clk);
        add_request(bia_pkg::REQ_ALLOC, 0);
        add_request(bia_pkg::REQ_QUERY, 2);
        add_request(bia_pkg::REQ_RELEASE, 2);
        add_request(bia_pkg::REQ_RELEASE, 1);
        add_request(bia_pkg::REQ_ALLOC, 0);

        // oversized pool saturates; hidden bits come back into view
        wait_drained();
        write_pool_size(2047);
        @(negedge clk);
        add_request(bia_pkg::REQ_QUERY, 2);
        add_request(bia_pkg::REQ_RELEASE, 0);
        add_request(bia_pkg::REQ_ALLOC, 0);
        add_request(bia_pkg::REQ_QUERY, 1023);

        // long receiver hold while requests keep coming
        wait_drained();
        long_hold_req = 1'b1;
        random_phase(16, 120);

        for (int p = 0; p < 12; p++)
        begin
            case ($urandom_range(0, 5))
                0: size = 1;
                1, 2: size = $urandom_range(2, 40);
                3: size = $urandom_range(2, 200);
                4:
                begin
                    case ($urandom_range(0, 2))
                        0: size = 1024;
                        1: size = 1025;
                        default: size = 2047;
                    endcase
                end
                default: size = $urandom_range(0, 2047);
            endcase
            random_phase(size, $urandom_range(70, 110));
        end

        // last stretch with no idling on either side
        wait_drained();
        calm = 1'b1;
        random_phase(32, 100);

        wait_drained();
        repeat (12) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== bitmap_id_allocator.f =====
rtl/bia_pkg.sv
rtl/bia_word_store.sv
rtl/bia_summary.sv
rtl/bitmap_id_allocator.sv
rtl/bia_checker.sv
tb/tb_bitmap_id_allocator.sv
